// ===== rtl/dvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants for the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int NODES_DEF = 64;
  localparam int PORTS_DEF = 8;

  localparam int FUNC_W = 3;
  localparam int NODE_W = 6;
  localparam int DIST_W = 8;
  localparam int PORT_W = 3;
  localparam int ACT_W  = 3;
  localparam int REACH_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADVERTISE = 3'd0,
    FN_FAILURE   = 3'd1,
    FN_LOGGER    = 3'd2,
    FN_PORT_DOWN = 3'd3,
    FN_LOOKUP    = 3'd4
  } func_code_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE       = 3'd0,
    ACT_FWD_ROUTE  = 3'd1,
    ACT_RPL_ROUTE  = 3'd2,
    ACT_FWD_FAIL   = 3'd3,
    ACT_FWD_LOGGER = 3'd4,
    ACT_RPL_LOGGER = 3'd5,
    ACT_FOUND      = 3'd6,
    ACT_NO_PATH    = 3'd7
  } action_t;

  typedef enum logic [REACH_W-1:0] {
    REACH_NONE = 2'd0,
    REACH_UP   = 2'd1,
    REACH_DOWN = 2'd2
  } reach_t;

  // Item kind after range checks in the front end.
  typedef enum logic [2:0] {
    K_NOP,
    K_ADV,
    K_FAIL,
    K_LOG,
    K_PDOWN,
    K_LOOKUP,
    K_NOPATH
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [NODE_W-1:0]  node;
    logic [DIST_W-1:0]  hop;
    logic [PORT_W-1:0]  port;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_EX,
    S_SCAN_END
  } state_t;

endpackage

// ===== rtl/dvrt_front.sv =====
// ----------------------------------------------------------------------------
// dvrt_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module dvrt_front
  import dvrt_pkg::*;
#(
  parameter int NODES = NODES_DEF,
  parameter int PORTS = PORTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [NODE_W-1:0] in_node_id,
  input  logic [DIST_W-1:0] in_hop_count,
  input  logic [PORT_W-1:0] in_arrival_port,
  input  back_stat_t        stat,
  output q_head_t           head
);

  item_t      q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      cls;
  logic       node_ok, port_ok, push;

  always_comb begin
    node_ok  = int'(in_node_id) < NODES;
    port_ok  = int'(in_arrival_port) < PORTS;
    cls.node = in_node_id;
    cls.hop  = in_hop_count;
    cls.port = in_arrival_port;
    unique case (in_func)
      FN_ADVERTISE: cls.kind = (node_ok && port_ok) ? K_ADV : K_NOP;
      FN_FAILURE:   cls.kind = (node_ok && port_ok) ? K_FAIL : K_NOP;
      FN_LOGGER:    cls.kind = K_LOG;
      FN_PORT_DOWN: cls.kind = port_ok ? K_PDOWN : K_NOP;
      FN_LOOKUP:    cls.kind = node_ok ? K_LOOKUP : K_NOPATH;
      default:      cls.kind = K_NOP;
    endcase
  end

  assign in_stall   = cnt_r[1] || stat.clearing;
  assign push       = in_valid && !in_stall;
  assign head.valid = cnt_r != 2'd0;
  assign head.item  = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = stat.pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(stat.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

endmodule

// ===== rtl/dvrt_back.sv =====
// ----------------------------------------------------------------------------
// dvrt_back
// Route memory, logger entry and the sequencer that carries out each item.
// ----------------------------------------------------------------------------
module dvrt_back
  import dvrt_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  q_head_t            head,
  output back_stat_t         stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ACT_W-1:0]   out_action,
  output logic [NODE_W-1:0]  out_node,
  output logic [DIST_W-1:0]  out_distance,
  output logic [PORT_W-1:0]  out_port,
  output logic [REACH_W-1:0] out_reachability_change,
  output logic               out_last_result
);

  localparam int IW = $clog2(NODES);

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] hops;
    logic [PORT_W-1:0] port;
  } entry_t;

  entry_t mem [NODES];
  entry_t rd_r, wdata;
  logic [IW-1:0] rd_addr, waddr;
  logic          we;

  state_t state_r, state_nxt;
  item_t  cur_r, cur_nxt;
  logic [IW-1:0] scan_r, scan_nxt, clr_r, clr_nxt;
  logic          held_v_r, held_v_nxt;
  logic [NODE_W-1:0] held_node_r, held_node_nxt;
  logic              lg_v_r, lg_v_nxt;
  logic [NODE_W-1:0] lg_node_r, lg_node_nxt;
  logic [DIST_W-1:0] lg_dist_r, lg_dist_nxt;

  logic               ov_r, ov_nxt, olast_r, olast_nxt;
  action_t            oact_r, oact_nxt;
  logic [NODE_W-1:0]  onode_r, onode_nxt;
  logic [DIST_W-1:0]  odist_r, odist_nxt;
  logic [PORT_W-1:0]  oport_r, oport_nxt;
  reach_t             oreach_r, oreach_nxt;

  logic              out_free, emit;
  logic [DIST_W:0]   d9;
  logic [DIST_W-1:0] dsat;
  logic              hit;

  assign out_free = !ov_r || !out_stall;
  assign d9   = {1'b0, cur_r.hop} + 9'd1;
  assign dsat = d9[DIST_W] ? '1 : d9[DIST_W-1:0];
  assign hit  = rd_r.valid && rd_r.port == cur_r.port;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    scan_nxt      = scan_r;
    clr_nxt       = clr_r;
    held_v_nxt    = held_v_r;
    held_node_nxt = held_node_r;
    lg_v_nxt      = lg_v_r;
    lg_node_nxt   = lg_node_r;
    lg_dist_nxt   = lg_dist_r;
    rd_addr       = IW'(cur_r.node);
    waddr         = IW'(cur_r.node);
    wdata         = rd_r;
    we            = 1'b0;
    stat.pop      = 1'b0;
    stat.clearing = 1'b0;
    emit          = 1'b0;
    oact_nxt      = ACT_NONE;
    onode_nxt     = '0;
    odist_nxt     = '0;
    oport_nxt     = '0;
    oreach_nxt    = REACH_NONE;
    olast_nxt     = 1'b1;

    unique case (state_r)
      S_CLEAR: begin
        stat.clearing = 1'b1;
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IW'(NODES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        rd_addr = IW'(head.item.node);
        if (head.valid) begin
          stat.pop   = 1'b1;
          cur_nxt    = head.item;
          scan_nxt   = '0;
          held_v_nxt = 1'b0;
          state_nxt  = (head.item.kind == K_PDOWN) ? S_SCAN_RD : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          case (cur_r.kind)
            K_ADV: begin
              if (!rd_r.valid || {1'b0, rd_r.hops} > d9) begin
                we         = 1'b1;
                wdata      = '{valid: 1'b1, hops: dsat, port: cur_r.port};
                oact_nxt   = ACT_FWD_ROUTE;
                onode_nxt  = cur_r.node;
                odist_nxt  = dsat;
                oreach_nxt = rd_r.valid ? REACH_NONE : REACH_UP;
              end else if ({1'b0, rd_r.hops} + 9'd1 < {1'b0, cur_r.hop}) begin
                oact_nxt  = ACT_RPL_ROUTE;
                onode_nxt = cur_r.node;
                odist_nxt = rd_r.hops;
              end
            end
            K_FAIL: begin
              if (hit) begin
                we          = 1'b1;
                wdata.valid = 1'b0;
                oact_nxt    = ACT_FWD_FAIL;
                onode_nxt   = cur_r.node;
                oreach_nxt  = REACH_DOWN;
                if (lg_v_r && lg_node_r == cur_r.node) begin
                  lg_v_nxt    = 1'b0;
                  lg_node_nxt = '0;
                  lg_dist_nxt = '0;
                end
              end else if (rd_r.valid) begin
                oact_nxt  = ACT_RPL_ROUTE;
                onode_nxt = cur_r.node;
                odist_nxt = rd_r.hops;
              end
            end
            K_LOG: begin
              if (!lg_v_r || {1'b0, lg_dist_r} > d9) begin
                lg_v_nxt    = 1'b1;
                lg_node_nxt = cur_r.node;
                lg_dist_nxt = dsat;
                oact_nxt    = ACT_FWD_LOGGER;
                onode_nxt   = cur_r.node;
                odist_nxt   = dsat;
              end else if ({1'b0, lg_dist_r} < d9) begin
                oact_nxt  = ACT_RPL_LOGGER;
                onode_nxt = lg_node_r;
                odist_nxt = lg_dist_r;
              end
            end
            K_LOOKUP: begin
              onode_nxt = cur_r.node;
              if (rd_r.valid) begin
                oact_nxt  = ACT_FOUND;
                odist_nxt = rd_r.hops;
                oport_nxt = rd_r.port;
              end else begin
                oact_nxt = ACT_NO_PATH;
              end
            end
            K_NOPATH: begin
              oact_nxt  = ACT_NO_PATH;
              onode_nxt = cur_r.node;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        rd_addr   = scan_r;
        state_nxt = S_SCAN_EX;
      end
      S_SCAN_EX: begin
        // One match is held back so that the final one can carry the last flag.
        rd_addr = scan_r;
        waddr   = scan_r;
        if (!hit || !held_v_r || out_free) begin
          if (hit) begin
            we            = 1'b1;
            wdata.valid   = 1'b0;
            held_v_nxt    = 1'b1;
            held_node_nxt = NODE_W'(scan_r);
            if (held_v_r) begin
              emit       = 1'b1;
              oact_nxt   = ACT_FWD_FAIL;
              onode_nxt  = held_node_r;
              oreach_nxt = REACH_DOWN;
              olast_nxt  = 1'b0;
            end
          end
          scan_nxt = scan_r + 1'b1;
          if (scan_r == IW'(NODES - 1)) state_nxt = S_SCAN_END;
          else                          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_END: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (held_v_r) begin
            oact_nxt   = ACT_FWD_FAIL;
            onode_nxt  = held_node_r;
            oreach_nxt = REACH_DOWN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = emit ? 1'b1 : (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      scan_r   <= '0;
      held_v_r <= 1'b0;
      lg_v_r   <= 1'b0;
      lg_node_r <= '0;
      lg_dist_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      scan_r   <= scan_nxt;
      held_v_r <= held_v_nxt;
      lg_v_r   <= lg_v_nxt;
      lg_node_r <= lg_node_nxt;
      lg_dist_r <= lg_dist_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    held_node_r <= held_node_nxt;
    if (emit) begin
      oact_r   <= oact_nxt;
      onode_r  <= onode_nxt;
      odist_r  <= odist_nxt;
      oport_r  <= oport_nxt;
      oreach_r <= oreach_nxt;
      olast_r  <= olast_nxt;
    end
  end

  assign out_valid               = ov_r;
  assign out_action              = oact_r;
  assign out_node                = onode_r;
  assign out_distance            = odist_r;
  assign out_port                = oport_r;
  assign out_reachability_change = oreach_r;
  assign out_last_result         = olast_r;

endmodule

// ===== rtl/distance_vector_route_table.sv =====
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Distance-vector routing table keyed by node number.
// ----------------------------------------------------------------------------
// Input transactions (in_*) carry a function code, a node, a hop count and a
// port. Each one produces one or more result transactions (out_*); the final
// result of an input has out_last_result set. A transaction moves at a clock
// edge where valid is high and stall is low.
// A front end classifies items into a two-entry queue; the back end owns the
// route memory and performs a read-modify-write per item.
// Advertise, failure, logger and lookup read the memory in the idle state, then
// compute, write and load the output register in the execute state. Between
// acceptance and out_valid lie the queue, the idle and the execute state.
// Port down scans the whole memory, reading and checking each entry in turn,
// and emits one result per removed route, or one empty result if none is.
// After reset the route memory is cleared entry by entry, during which
// in_stall is high. When out_stall is high the output register holds
// its result and the back end waits; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module distance_vector_route_table
  import dvrt_pkg::*;
#(
  parameter int NODES = NODES_DEF,
  parameter int PORTS = PORTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [NODE_W-1:0]  in_node_id,
  input  logic [DIST_W-1:0]  in_hop_count,
  input  logic [PORT_W-1:0]  in_arrival_port,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ACT_W-1:0]   out_action,
  output logic [NODE_W-1:0]  out_node,
  output logic [DIST_W-1:0]  out_distance,
  output logic [PORT_W-1:0]  out_port,
  output logic [REACH_W-1:0] out_reachability_change,
  output logic               out_last_result
);

  q_head_t    head;
  back_stat_t stat;

  dvrt_front #(.NODES(NODES), .PORTS(PORTS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_node_id,
    .in_hop_count, .in_arrival_port, .stat, .head
  );

  dvrt_back #(.NODES(NODES)) u_back (
    .clk, .rst_n, .head, .stat, .out_valid, .out_stall, .out_action,
    .out_node, .out_distance, .out_port, .out_reachability_change,
    .out_last_result
  );

endmodule

// ===== rtl/dvrt_checker.sv =====
// ----------------------------------------------------------------------------
// dvrt_checker
// Port-level checks on the route table result channel.
// ----------------------------------------------------------------------------
module dvrt_checker
  import dvrt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [ACT_W-1:0]   out_action,
  input logic [NODE_W-1:0]  out_node,
  input logic [DIST_W-1:0]  out_distance,
  input logic [REACH_W-1:0] out_reachability_change,
  input logic               out_last_result
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_node) && $stable(out_action))
    else $error("stalled result transaction changed");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_NONE |-> out_last_result && out_node == '0
      && out_distance == '0)
    else $error("empty result is not a lone zeroed last result");

  a_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reachability_change == REACH_UP |-> out_action == ACT_FWD_ROUTE)
    else $error("reachable flag without a forwarded route");

  a_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_FWD_FAIL |->
      out_reachability_change == REACH_DOWN && out_distance == '0)
    else $error("forwarded failure without unreachable flag");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_action, .out_node, .out_distance,
  .out_reachability_change, .out_last_result
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Route table testbench
// Drives advertisements, failures, logger adverts, port-down and lookup
// transactions into the route table. A local model of the table predicts the
// result transactions, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import dvrt_pkg::*;

  localparam int NUM_NODES = 64;
  localparam int NUM_PORTS = 8;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [NODE_W-1:0]  node;
    logic [DIST_W-1:0]  distance;
    logic [PORT_W-1:0]  port;
    logic [REACH_W-1:0] reach;
    logic               last;
  } route_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [FUNC_W-1:0] in_func;
  logic [NODE_W-1:0] in_node_id;
  logic [DIST_W-1:0] in_hop_count;
  logic [PORT_W-1:0] in_arrival_port;
  logic out_valid;
  logic out_stall;
  logic [ACT_W-1:0] out_action;
  logic [NODE_W-1:0] out_node;
  logic [DIST_W-1:0] out_distance;
  logic [PORT_W-1:0] out_port;
  logic [REACH_W-1:0] out_reachability_change;
  logic out_last_result;

  // Local copy of the table.
  logic               tbl_valid [NUM_NODES];
  logic [DIST_W-1:0]  tbl_dist [NUM_NODES];
  logic [PORT_W-1:0]  tbl_port [NUM_NODES];
  logic               lg_valid;
  logic [NODE_W-1:0]  lg_node;
  logic [DIST_W-1:0]  lg_dist;

  route_result_t expected_results[$];
  int mismatches;
  int idle_cycles;
  bit hold_off;
  int burst_left;

  distance_vector_route_table DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic route_result_t make_result(action_t act, int node, int distance,
                                                int port, reach_t reach);
    route_result_t r;
    r.action = act;
    r.node = NODE_W'(node);
    r.distance = DIST_W'(distance);
    r.port = PORT_W'(port);
    r.reach = reach;
    r.last = 1'b0;
    return r;
  endfunction

  // Updates the local table and queues the results the item causes.
  task automatic predict_routes(logic [FUNC_W-1:0] fn, logic [NODE_W-1:0] node,
                                logic [DIST_W-1:0] hop, logic [PORT_W-1:0] port);
    route_result_t res[$];
    logic [8:0] d;
    logic [DIST_W-1:0] ds;
    d = hop + 9'd1;
    ds = (d > 9'd255) ? 8'd255 : d[7:0];
    case (fn)
      FN_ADVERTISE: begin
        if (!tbl_valid[node]) begin
          tbl_valid[node] = 1'b1;
          tbl_dist[node] = ds;
          tbl_port[node] = port;
          res.insert(res.size(), make_result(ACT_FWD_ROUTE, node, ds, 0, REACH_UP));
        end else if ({1'b0, tbl_dist[node]} > d) begin
          tbl_dist[node] = ds;
          tbl_port[node] = port;
          res.insert(res.size(), make_result(ACT_FWD_ROUTE, node, ds, 0, REACH_NONE));
        end else if ({1'b0, tbl_dist[node]} + 9'd1 < {1'b0, hop}) begin
          res.insert(res.size(),
                     make_result(ACT_RPL_ROUTE, node, tbl_dist[node], 0, REACH_NONE));
        end
      end
      FN_FAILURE: begin
        if (tbl_valid[node]) begin
          if (tbl_port[node] == port) begin
            tbl_valid[node] = 1'b0;
            if (lg_valid && lg_node == node) begin
              lg_valid = 1'b0;
              lg_node = '0;
              lg_dist = '0;
            end
            res.insert(res.size(), make_result(ACT_FWD_FAIL, node, 0, 0, REACH_DOWN));
          end else begin
            res.insert(res.size(),
                       make_result(ACT_RPL_ROUTE, node, tbl_dist[node], 0, REACH_NONE));
          end
        end
      end
      FN_LOGGER: begin
        if (!lg_valid || {1'b0, lg_dist} > d) begin
          lg_valid = 1'b1;
          lg_node = node;
          lg_dist = ds;
          res.insert(res.size(), make_result(ACT_FWD_LOGGER, node, ds, 0, REACH_NONE));
        end else if ({1'b0, lg_dist} < d) begin
          res.insert(res.size(),
                     make_result(ACT_RPL_LOGGER, lg_node, lg_dist, 0, REACH_NONE));
        end
      end
      FN_PORT_DOWN: begin
        for (int i = 0; i < NUM_NODES; i++) begin
          if (tbl_valid[i] && tbl_port[i] == port) begin
            tbl_valid[i] = 1'b0;
            res.insert(res.size(), make_result(ACT_FWD_FAIL, i, 0, 0, REACH_DOWN));
          end
        end
      end
      FN_LOOKUP: begin
        if (tbl_valid[node])
          res.insert(res.size(), make_result(ACT_FOUND, node, tbl_dist[node],
                                             tbl_port[node], REACH_NONE));
        else
          res.insert(res.size(), make_result(ACT_NO_PATH, node, 0, 0, REACH_NONE));
      end
      default: ;
    endcase
    if (res.size() == 0) res.insert(0, make_result(ACT_NONE, 0, 0, 0, REACH_NONE));
    res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_results.insert(expected_results.size(), res[i]);
  endtask

  // Sends one transaction; the sender pauses between bursts of random length.
  task automatic send_item(logic [FUNC_W-1:0] fn, logic [NODE_W-1:0] node,
                           logic [DIST_W-1:0] hop, logic [PORT_W-1:0] port);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func <= fn;
    in_node_id <= node;
    in_hop_count <= hop;
    in_arrival_port <= port;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_routes(fn, node, hop, port);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic test_directed_extremes;
    send_item(FN_LOOKUP, 6'd0, 8'd0, 3'd0);
    send_item(FN_ADVERTISE, 6'd0, 8'd0, 3'd0);
    send_item(FN_ADVERTISE, 6'd63, 8'd255, 3'd7);   // saturates at 255
    send_item(FN_ADVERTISE, 6'd63, 8'd254, 3'd5);   // equal distance, nothing
    send_item(FN_ADVERTISE, 6'd63, 8'd10, 3'd2);    // improvement
    send_item(FN_ADVERTISE, 6'd63, 8'd200, 3'd4);   // reply with shorter route
    send_item(FN_LOOKUP, 6'd63, 8'd0, 3'd0);
    send_item(FN_FAILURE, 6'd63, 8'd0, 3'd6);       // other port: reply
    send_item(FN_FAILURE, 6'd5, 8'd0, 3'd1);        // no route: nothing
    send_item(FN_LOGGER, 6'd40, 8'd255, 3'd0);
    send_item(FN_LOGGER, 6'd41, 8'd3, 3'd1);
    send_item(FN_LOGGER, 6'd42, 8'd100, 3'd1);
    send_item(FN_LOGGER, 6'd43, 8'd3, 3'd1);        // equal: nothing
    send_item(FN_ADVERTISE, 6'd41, 8'd7, 3'd3);
    send_item(FN_FAILURE, 6'd41, 8'd0, 3'd3);       // clears the logger too
    send_item(FN_LOGGER, 6'd12, 8'd50, 3'd0);
    send_item(FN_ADVERTISE, 6'd20, 8'd1, 3'd2);
    send_item(FN_PORT_DOWN, 6'd0, 8'd0, 3'd2);
    send_item(FN_PORT_DOWN, 6'd0, 8'd0, 3'd1);      // nothing through it
    send_item(3'd5, 6'd1, 8'd1, 3'd1);
    send_item(3'd6, 6'd2, 8'd2, 3'd2);
    send_item(3'd7, 6'd63, 8'd255, 3'd7);
    send_item(FN_FAILURE, 6'd0, 8'd255, 3'd0);
    drain();
  endtask

  task automatic test_random_traffic(int count, int port_span);
    int r;
    int fn;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) fn = FN_ADVERTISE;
      else if (r < 55) fn = FN_FAILURE;
      else if (r < 65) fn = FN_LOGGER;
      else if (r < 70) fn = FN_PORT_DOWN;
      else if (r < 97) fn = FN_LOOKUP;
      else fn = $urandom_range(5, 7);
      send_item(FUNC_W'(fn),
                NODE_W'((i % 4 == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15)),
                DIST_W'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                             : $urandom_range(0, 12)),
                PORT_W'($urandom_range(0, port_span)));
    end
    drain();
  endtask

  // Holds the output off for a long stretch while inputs keep coming.
  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random_traffic(77, 7);
    join
  endtask

  // Receiver stall pattern plus the hold-off.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || (($urandom_range(0, 3) == 0) && ($urandom_range(0, 9) > 3));
  end

  always @(posedge clk) begin
    route_result_t got;
    route_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_action, out_node, out_distance, out_port, out_reachability_change,
             out_last_result};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp act %0d node %0d dist %0d port %0d reach %0d ",
                      "last %0d, got act %0d node %0d dist %0d port %0d reach %0d ",
                      "last %0d"},
                     exp_r.action, exp_r.node, exp_r.distance, exp_r.port, exp_r.reach,
                     exp_r.last, got.action, got.node, got.distance, got.port, got.reach,
                     got.last);
        end
      end
    end
  end

  // Watchdog: counts cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_node_id = '0;
    in_hop_count = '0;
    in_arrival_port = '0;
    burst_left = 0;
    lg_valid = 1'b0;
    lg_node = '0;
    lg_dist = '0;
    for (int i = 0; i < NUM_NODES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_dist[i] = '0;
      tbl_port[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_random_traffic(150, 7);
    test_random_traffic(130, 2);
    test_backpressure();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dvrt_pkg.sv
rtl/dvrt_front.sv
rtl/dvrt_back.sv
rtl/distance_vector_route_table.sv
rtl/dvrt_checker.sv
verif/testbench.sv
